// File: hw/rtl/rrss_pkg.sv
// Package for the round robin sleep scheduler.
// Holds the slot count, field widths, opcode and slot state codes, the slot record
// and status types, and the ring successor function. Depends on nothing.
`default_nettype none

package rrss_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);
   localparam int OP_W      = 3;
   localparam int TICK_W    = 32;
   localparam int SLEEP_W   = TICK_W + 1;
   localparam int ID_W      = 4;

   typedef enum logic [OP_W-1:0] {
      OP_TICK   = 3'd0,
      OP_SLEEP  = 3'd1,
      OP_EXIT   = 3'd2,
      OP_ALARM  = 3'd3,
      OP_CREATE = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_UNUSED  = 2'd0,
      ST_READY   = 2'd1,
      ST_RUNNING = 2'd2,
      ST_WAITING = 2'd3
   } slot_state_type;

   typedef struct packed {
      slot_state_type     state;
      logic [SLEEP_W-1:0] sleep;
      logic [TICK_W-1:0]  period;
      logic [TICK_W-1:0]  remain;
   } slot_rec_type;

   typedef struct packed {
      logic              busy;
      logic              halted;
      logic [SLOT_W-1:0] current;
      logic [SLOT_W-1:0] head;
   } ctrl_status_type;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      return (s == SLOT_W'(NUM_SLOTS - 1)) ? '0 : s + 1'b1;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rrss_if.sv
// Request and response channel interfaces of the round robin sleep scheduler.
// Each carries valid, ready and one beat of payload. Depends on rrss_pkg.
`default_nettype none

interface rrss_req_if import rrss_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [TICK_W-1:0] tick_count;
   logic [ID_W-1:0]   slot_id;

   modport source (output valid, output opcode, output tick_count, output slot_id,
                   input ready);
   modport sink (input valid, input opcode, input tick_count, input slot_id,
                 output ready);
endinterface

interface rrss_rsp_if ();
   logic       valid;
   logic       ready;
   logic [3:0] running_slot;
   logic       switched;
   logic       alarm_fired;
   logic       halted;

   modport source (output valid, output running_slot, output switched,
                   output alarm_fired, output halted, input ready);
   modport sink (input valid, input running_slot, input switched,
                 input alarm_fired, input halted, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rrss_cell.sv
// One cell of the slot ring: holds the record of one slot and passes it on.
// Depends on rrss_pkg.
`default_nettype none

module rrss_cell import rrss_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         shift,
   input  wire slot_rec_type reset_value,
   input  wire slot_rec_type data_in,
   output slot_rec_type      data_out
);

   slot_rec_type rec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff <= reset_value;
      end else if (shift) begin
         rec_ff <= data_in;
      end
   end

   assign data_out = rec_ff;

endmodule

`default_nettype wire

// File: hw/rtl/rrss_ctrl.sv
// Event controller of the scheduler: takes request beats, works on the slot record
// at the head of the ring as it rotates, and sends response beats.
// Depends on rrss_pkg and the channel interfaces.
`default_nettype none

module rrss_ctrl import rrss_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   rrss_req_if.sink          req_ch,
   rrss_rsp_if.source        rsp_ch,
   input  wire slot_rec_type head_rec,
   output slot_rec_type      tail_rec,
   output logic              shift,
   output ctrl_status_type   status
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_MAIN   = 4'b0010,
      S_SETTLE = 4'b0100,
      S_DONE   = 4'b1000
   } ctrl_state_type;

   ctrl_state_type    state_ff, state_in;
   logic              halt_ff, halt_in;
   logic [SLOT_W-1:0] cur_ff, cur_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic              found_ff, found_in;
   logic [SLOT_W-1:0] nx_ff, nx_in;
   logic              wait_ff, wait_in;
   logic              used_ff, used_in;
   logic              zero_run_ff, zero_run_in;
   logic              copy_ff, copy_in;
   logic              lap_ff, lap_in;
   logic              fired_ff, fired_in;
   logic              rsp_valid_ff, rsp_valid_in;

   opcode_type        op_ff, op_in;
   logic [TICK_W-1:0] ticks_ff, ticks_in;
   logic [SLOT_W-1:0] sid_ff, sid_in;
   logic [SLOT_W-1:0] old_cur_ff, old_cur_in;
   slot_rec_type      cap_ff, cap_in;
   logic [3:0]        rsp_slot_ff, rsp_slot_in;
   logic              rsp_sw_ff, rsp_sw_in;
   logic              rsp_fired_ff, rsp_fired_in;
   logic              rsp_halt_ff, rsp_halt_in;

   always_comb begin
      slot_rec_type rec;
      logic         is_cur;
      logic         is_zero;
      logic         active;
      logic         can_claim;

      state_in     = state_ff;
      halt_in      = halt_ff;
      cur_in       = cur_ff;
      head_in      = head_ff;
      found_in     = found_ff;
      nx_in        = nx_ff;
      wait_in      = wait_ff;
      used_in      = used_ff;
      zero_run_in  = zero_run_ff;
      copy_in      = copy_ff;
      lap_in       = lap_ff;
      fired_in     = fired_ff;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      ticks_in     = ticks_ff;
      sid_in       = sid_ff;
      old_cur_in   = old_cur_ff;
      cap_in       = cap_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_sw_in    = rsp_sw_ff;
      rsp_fired_in = rsp_fired_ff;
      rsp_halt_in  = rsp_halt_ff;

      rec       = head_rec;
      is_cur    = (head_ff == cur_ff);
      is_zero   = (head_ff == '0);
      active    = !halt_ff;
      can_claim = 1'b0;
      shift     = 1'b0;

      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in       = opcode_type'(req_ch.opcode);
               ticks_in    = req_ch.tick_count;
               sid_in      = SLOT_W'(req_ch.slot_id);
               old_cur_in  = cur_ff;
               found_in    = 1'b0;
               nx_in       = '0;
               wait_in     = 1'b0;
               used_in     = 1'b0;
               zero_run_in = 1'b0;
               fired_in    = 1'b0;
               lap_in      = (opcode_type'(req_ch.opcode) == OP_CREATE);
               copy_in     = active && (opcode_type'(req_ch.opcode) == OP_CREATE) &&
                             (req_ch.slot_id != '0) && (int'(req_ch.slot_id) < NUM_SLOTS);
               state_in    = S_MAIN;
            end
         end

         S_MAIN: begin
            shift   = 1'b1;
            head_in = next_slot(head_ff);

            // Sleep counts of waiting slots run down on every tick while the scheduler is not halted.
            if (active && op_ff == OP_TICK && rec.state == ST_WAITING) begin
               if (rec.sleep <= SLEEP_W'(2)) begin
                  rec.state = ST_READY;
               end
               if (rec.sleep != '0) begin
                  rec.sleep = rec.sleep - SLEEP_W'(1);
               end
            end

            // On tick, sleep or exit the first ready nonzero slot after the current one is claimed.
            case (op_ff) inside
               OP_TICK, OP_SLEEP: can_claim = 1'b1;
               OP_EXIT:           can_claim = (cur_ff != '0);
               default:           can_claim = 1'b0;
            endcase
            if (active && can_claim && !is_cur && !is_zero && !found_ff &&
                rec.state == ST_READY) begin
               rec.state = ST_RUNNING;
               if (op_ff == OP_TICK) begin
                  rec.sleep = '0;
               end
               found_in = 1'b1;
               nx_in    = head_ff;
            end

            if (rec.state == ST_WAITING) begin
               wait_in = 1'b1;
            end
            if (!is_cur && !is_zero && head_rec.state != ST_UNUSED) begin
               used_in = 1'b1;
            end

            if (is_cur) begin
               cap_in   = head_rec;
               state_in = S_SETTLE;
               if (active) begin
                  case (op_ff)
                     OP_TICK: begin
                        if (found_ff) begin
                           if (rec.state == ST_RUNNING) begin
                              rec.state = ST_READY;
                           end
                           cur_in = nx_ff;
                        end else if (!wait_in && is_zero) begin
                           halt_in = 1'b1;
                        end else if (rec.period != '0) begin
                           if (rec.remain <= TICK_W'(1)) begin
                              rec.remain = rec.period;
                              fired_in   = 1'b1;
                           end else begin
                              rec.remain = rec.remain - TICK_W'(1);
                           end
                        end
                     end
                     OP_SLEEP: begin
                        rec.sleep = {1'b0, ticks_ff} + SLEEP_W'(1);
                        rec.state = ST_WAITING;
                        if (found_ff) begin
                           cur_in = nx_ff;
                        end else if (is_zero) begin
                           rec.state = ST_RUNNING;
                        end else begin
                           cur_in      = '0;
                           zero_run_in = 1'b1;
                        end
                     end
                     OP_EXIT: begin
                        rec.state = ST_UNUSED;
                        if (is_zero) begin
                           halt_in = 1'b1;
                        end else if (found_ff) begin
                           cur_in = nx_ff;
                        end else if (!used_ff) begin
                           halt_in = 1'b1;
                        end else begin
                           cur_in      = '0;
                           zero_run_in = 1'b1;
                        end
                     end
                     OP_ALARM: begin
                        rec.period = ticks_ff;
                        rec.remain = ticks_ff;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end

         S_SETTLE: begin
            if (head_ff == next_slot(cur_ff) && !lap_ff) begin
               state_in = S_DONE;
            end else begin
               shift   = 1'b1;
               head_in = next_slot(head_ff);
               lap_in  = 1'b0;
               if (zero_run_ff && is_zero) begin
                  rec.state = ST_RUNNING;
               end
               if (copy_ff && head_ff == sid_ff && rec.state == ST_UNUSED) begin
                  rec.state  = ST_READY;
                  rec.sleep  = cap_ff.sleep;
                  rec.period = cap_ff.period;
                  rec.remain = cap_ff.remain;
               end
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = 4'(cur_ff);
               rsp_sw_in    = (cur_ff != old_cur_ff);
               rsp_fired_in = fired_ff;
               rsp_halt_in  = halt_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      tail_rec = rec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         halt_ff      <= 1'b0;
         cur_ff       <= '0;
         head_ff      <= next_slot('0);
         found_ff     <= 1'b0;
         nx_ff        <= '0;
         wait_ff      <= 1'b0;
         used_ff      <= 1'b0;
         zero_run_ff  <= 1'b0;
         copy_ff      <= 1'b0;
         lap_ff       <= 1'b0;
         fired_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         halt_ff      <= halt_in;
         cur_ff       <= cur_in;
         head_ff      <= head_in;
         found_ff     <= found_in;
         nx_ff        <= nx_in;
         wait_ff      <= wait_in;
         used_ff      <= used_in;
         zero_run_ff  <= zero_run_in;
         copy_ff      <= copy_in;
         lap_ff       <= lap_in;
         fired_ff     <= fired_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      ticks_ff     <= ticks_in;
      sid_ff       <= sid_in;
      old_cur_ff   <= old_cur_in;
      cap_ff       <= cap_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_sw_ff    <= rsp_sw_in;
      rsp_fired_ff <= rsp_fired_in;
      rsp_halt_ff  <= rsp_halt_in;
   end

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.running_slot = rsp_slot_ff;
   assign rsp_ch.switched     = rsp_sw_ff;
   assign rsp_ch.alarm_fired  = rsp_fired_ff;
   assign rsp_ch.halted       = rsp_halt_ff;

   assign status.busy    = (state_ff != S_IDLE);
   assign status.halted  = halt_ff;
   assign status.current = cur_ff;
   assign status.head    = head_ff;

endmodule

`default_nettype wire

// File: hw/rtl/round_robin_sleep_scheduler.sv
// Round robin sleep scheduler: a ring of NUM_SLOTS slot cells that rotates past one controller.
// An event rotates the ring in the main state until the running slot reaches the head, then
// the settle state rotates on until the head follows the running slot again (a lap on a create).
// One event is in work at a time: no request beat is taken until its response beat is loaded,
// which waits while the previous response beat is still held.
// Synchronous reset: slot 0 running, all other slots unused, all counters zero.
`default_nettype none

module round_robin_sleep_scheduler import rrss_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   rrss_req_if.sink   req_ch,
   rrss_rsp_if.source rsp_ch
);

   slot_rec_type    cell_q    [NUM_SLOTS];
   slot_rec_type    cell_init [NUM_SLOTS];
   slot_rec_type    tail_rec;
   logic            shift;
   ctrl_status_type status;

   // After reset the head cell holds slot 1, so slot 0 sits in the last cell.
   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      assign cell_init[i].state  = (i == NUM_SLOTS - 1) ? ST_RUNNING : ST_UNUSED;
      assign cell_init[i].sleep  = '0;
      assign cell_init[i].period = '0;
      assign cell_init[i].remain = '0;

      if (i == NUM_SLOTS - 1) begin : g_tail
         rrss_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .shift       (shift),
            .reset_value (cell_init[i]),
            .data_in     (tail_rec),
            .data_out    (cell_q[i])
         );
      end else begin : g_body
         rrss_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .shift       (shift),
            .reset_value (cell_init[i]),
            .data_in     (cell_q[i+1]),
            .data_out    (cell_q[i])
         );
      end
   end

   rrss_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .head_rec (cell_q[0]),
      .tail_rec (tail_rec),
      .shift    (shift),
      .status   (status)
   );

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      status.halted |=> status.halted)
      else $error("halt flag cleared");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> status.busy)
      else $error("accepted beat did not start work");

   a_halt_frozen: assert property (@(posedge clock) disable iff (reset)
      (status.halted && $past(status.halted)) |-> status.current == $past(status.current))
      else $error("running slot changed while halted");

   a_ring_aligned: assert property (@(posedge clock) disable iff (reset)
      !status.busy |-> status.head == next_slot(status.current))
      else $error("ring head not aligned after the running slot");

endmodule

`default_nettype wire
